FILE: rtl/mcsl_pkg.sv
`timescale 1ns / 1ps

package mcsl_pkg;

  localparam int NUM_CHANNELS = 10;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 4;
  localparam int POWER_W   = 8;
  localparam int STEP_W    = 9;
  localparam int CALC_W    = 11;

  typedef logic [ACTION_W-1:0] action_t;

  localparam action_t ACT_TICK      = 2'd0;
  localparam action_t ACT_SET_POWER = 2'd1;
  localparam action_t ACT_SET_STEP  = 2'd2;

  localparam logic [STEP_W-1:0]         STEP_RESET = 9'd10;
  localparam logic signed [POWER_W-1:0] POWER_MIN  = -8'sd127;
  localparam logic signed [POWER_W-1:0] POWER_LOW  = -8'sd128;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic signed [POWER_W-1:0] target;
    logic [STEP_W-1:0]         step;
  } chan_param_t;

endpackage

FILE: rtl/mcsl_in_if.sv
`timescale 1ns / 1ps

interface mcsl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mcsl_pkg::ACTION_W-1:0]         action;
  logic [mcsl_pkg::CHANNEL_W-1:0]        channel;
  logic signed [mcsl_pkg::POWER_W-1:0]   requested_power;
  logic [mcsl_pkg::STEP_W-1:0]           slew_step;

  modport source (output valid, action, channel, requested_power, slew_step, input ready);
  modport sink   (input valid, action, channel, requested_power, slew_step, output ready);
endinterface

FILE: rtl/mcsl_out_if.sv
`timescale 1ns / 1ps

interface mcsl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mcsl_pkg::CHANNEL_W-1:0]        out_channel;
  logic signed [mcsl_pkg::POWER_W-1:0]   power;
  logic                                  last;

  modport source (output valid, out_channel, power, last, input ready);
  modport sink   (input valid, out_channel, power, last, output ready);
endinterface

FILE: rtl/multi_channel_slew_limiter.sv
`timescale 1ns / 1ps

// Multi-channel slew limiter.
// in_bus carries commands: set a channel's target power, set its slew step, or
// tick. Set beats produce no output. A tick walks channels 0 .. NUM_CHANNELS-1,
// moves each present power toward its target by at most its step (in the
// accelerate-only mode, straight to a target of zero or of the same sign and
// no larger magnitude), and sends one out_bus beat per channel; the final beat
// has last set. cfg_wr_en/cfg_wr_data write the accelerate-only mode bit; the
// user must write it while idle only, as the block does not enforce this.
// Each channel is read into the read registers, then moved to the output
// register; one result per cycle when out_bus never stalls, a rate set by the
// single read port of the channel tables. in_bus is ready whenever no tick is
// in progress, also while the final result still waits in the output register.
// When out_bus stalls, the walk holds: the read data for the next channel stays
// registered until the output register frees up.
// Reset clears the mode bit, all targets and present powers to zero and all
// steps to ten (per-entry valid bits, no clearing pass).

module multi_channel_slew_limiter (
  input  logic              clk,
  input  logic              rst_n,
  mcsl_in_if.sink           in_bus,
  mcsl_out_if.source        out_bus,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);

  localparam int N = mcsl_pkg::NUM_CHANNELS;

  mcsl_pkg::state_t state_r, state_nxt;

  mcsl_pkg::chan_param_t                 prm_mem [N];
  logic signed [mcsl_pkg::POWER_W-1:0]   prs_mem [N];
  logic [N-1:0]                          tgt_vld_r;
  logic [N-1:0]                          stp_vld_r;
  logic [N-1:0]                          prs_vld_r;

  logic                                  acc_only_r;
  logic [mcsl_pkg::CNT_W-1:0]            rd_cnt_r;
  logic                                  s1_vld_r;
  logic [mcsl_pkg::IDX_W-1:0]            s1_idx_r;
  mcsl_pkg::chan_param_t                 prm_rd_r;
  logic signed [mcsl_pkg::POWER_W-1:0]   prs_rd_r;

  logic                                  out_vld_r;
  logic [mcsl_pkg::CHANNEL_W-1:0]        out_ch_r;
  logic signed [mcsl_pkg::POWER_W-1:0]   out_pwr_r;
  logic                                  out_last_r;

  logic                                  in_acc;
  logic                                  tick_acc;
  logic                                  set_ok;
  logic [mcsl_pkg::IDX_W-1:0]            set_idx;
  logic [mcsl_pkg::IDX_W-1:0]            rd_idx;
  logic signed [mcsl_pkg::POWER_W-1:0]   tgt_wr;
  logic                                  out_free;
  logic                                  adv;
  logic                                  rd_en;
  logic                                  in_rdy;
  logic                                  last_ch;

  logic signed [mcsl_pkg::CALC_W-1:0]    now_x;
  logic signed [mcsl_pkg::CALC_W-1:0]    goal_x;
  logic signed [mcsl_pkg::CALC_W-1:0]    step_x;
  logic signed [mcsl_pkg::CALC_W-1:0]    up_x;
  logic signed [mcsl_pkg::CALC_W-1:0]    dn_x;
  logic signed [mcsl_pkg::CALC_W-1:0]    mag_now;
  logic signed [mcsl_pkg::CALC_W-1:0]    mag_goal;
  logic signed [mcsl_pkg::CALC_W-1:0]    nxt_x;
  logic                                  same_sign;
  logic signed [mcsl_pkg::POWER_W-1:0]   pwr_nxt;

  assign in_acc   = in_bus.valid && in_rdy;
  assign tick_acc = in_acc && (in_bus.action == mcsl_pkg::ACT_TICK);
  assign set_ok   = int'(in_bus.channel) < N;
  assign set_idx  = mcsl_pkg::IDX_W'(in_bus.channel);
  assign rd_idx   = rd_cnt_r[mcsl_pkg::IDX_W-1:0];
  assign tgt_wr   = (in_bus.requested_power == mcsl_pkg::POWER_LOW) ?
                    mcsl_pkg::POWER_MIN : in_bus.requested_power;
  assign out_free = !out_vld_r || out_bus.ready;
  assign adv      = s1_vld_r && out_free;
  assign last_ch  = s1_idx_r == mcsl_pkg::IDX_W'(N - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcsl_pkg::ST_IDLE: if (tick_acc) state_nxt = mcsl_pkg::ST_RUN;
      mcsl_pkg::ST_RUN:  if (adv && last_ch) state_nxt = mcsl_pkg::ST_IDLE;
      default:           state_nxt = mcsl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy = 1'b0;
    rd_en  = 1'b0;
    unique case (state_r)
      mcsl_pkg::ST_IDLE: in_rdy = 1'b1;
      mcsl_pkg::ST_RUN:  rd_en  = (int'(rd_cnt_r) < N) && (!s1_vld_r || adv);
      default:           in_rdy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mcsl_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // advance one channel
  always_comb begin
    now_x     = mcsl_pkg::CALC_W'(prs_rd_r);
    goal_x    = mcsl_pkg::CALC_W'(prm_rd_r.target);
    step_x    = $signed({2'b00, prm_rd_r.step});
    up_x      = now_x + step_x;
    dn_x      = now_x - step_x;
    mag_now   = (now_x < 0) ? -now_x : now_x;
    mag_goal  = (goal_x < 0) ? -goal_x : goal_x;
    same_sign = (goal_x > 0 && now_x > 0) || (goal_x < 0 && now_x < 0);
    priority if (acc_only_r && (goal_x == 0 || (same_sign && mag_goal <= mag_now))) begin
      nxt_x = goal_x;
    end else if (goal_x > now_x) begin
      nxt_x = (up_x > goal_x) ? goal_x : up_x;
    end else if (goal_x < now_x) begin
      nxt_x = (dn_x < goal_x) ? goal_x : dn_x;
    end else begin
      nxt_x = now_x;
    end
    pwr_nxt = nxt_x[mcsl_pkg::POWER_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_only_r <= 1'b0;
      rd_cnt_r   <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      tgt_vld_r  <= '0;
      stp_vld_r  <= '0;
      prs_vld_r  <= '0;
    end else begin
      if (cfg_wr_en) acc_only_r <= cfg_wr_data;
      if (tick_acc) rd_cnt_r <= '0;
      else if (rd_en) rd_cnt_r <= rd_cnt_r + 1'b1;
      if (rd_en) s1_vld_r <= 1'b1;
      else if (adv) s1_vld_r <= 1'b0;
      if (adv) out_vld_r <= 1'b1;
      else if (out_bus.ready) out_vld_r <= 1'b0;
      if (in_acc && set_ok && in_bus.action == mcsl_pkg::ACT_SET_POWER)
        tgt_vld_r[set_idx] <= 1'b1;
      if (in_acc && set_ok && in_bus.action == mcsl_pkg::ACT_SET_STEP)
        stp_vld_r[set_idx] <= 1'b1;
      if (adv) prs_vld_r[s1_idx_r] <= 1'b1;
    end
  end

  // parameter table: written by set beats, read during the walk
  always_ff @(posedge clk) begin
    if (in_acc && set_ok && in_bus.action == mcsl_pkg::ACT_SET_POWER)
      prm_mem[set_idx].target <= tgt_wr;
    if (in_acc && set_ok && in_bus.action == mcsl_pkg::ACT_SET_STEP)
      prm_mem[set_idx].step <= in_bus.slew_step;
    if (rd_en) begin
      prm_rd_r.target <= tgt_vld_r[rd_idx] ? prm_mem[rd_idx].target : '0;
      prm_rd_r.step   <= stp_vld_r[rd_idx] ? prm_mem[rd_idx].step : mcsl_pkg::STEP_RESET;
    end
  end

  // present power table: the write goes to the channel before the one being read
  always_ff @(posedge clk) begin
    if (adv) prs_mem[s1_idx_r] <= pwr_nxt;
    if (rd_en) begin
      prs_rd_r <= prs_vld_r[rd_idx] ? prs_mem[rd_idx] : '0;
      s1_idx_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch_r   <= mcsl_pkg::CHANNEL_W'(s1_idx_r);
      out_pwr_r  <= pwr_nxt;
      out_last_r <= last_ch;
    end
  end

  assign in_bus.ready        = in_rdy;
  assign out_bus.valid       = out_vld_r;
  assign out_bus.out_channel = out_ch_r;
  assign out_bus.power       = out_pwr_r;
  assign out_bus.last        = out_last_r;

endmodule

FILE: rtl/mcsl_checker.sv
`timescale 1ns / 1ps

module mcsl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [mcsl_pkg::ACTION_W-1:0]       in_action,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [mcsl_pkg::CHANNEL_W-1:0]      out_channel,
  input logic signed [mcsl_pkg::POWER_W-1:0] out_power,
  input logic                                out_last
);

  // hold a stalled beat
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_power)
                                && $stable(out_last))
    else $error("stalled output beat changed");

  // a tick closes the input until its walk ends
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == mcsl_pkg::ACT_TICK |=> !in_ready)
    else $error("input ready right after a tick");

  // a pending non-final result means the walk is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a tick");

  // the final beat reports the highest channel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      out_channel == mcsl_pkg::CHANNEL_W'(mcsl_pkg::NUM_CHANNELS - 1))
    else $error("last beat on wrong channel");

endmodule

bind multi_channel_slew_limiter mcsl_checker u_mcsl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .in_action   (in_bus.action),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_channel (out_bus.out_channel),
  .out_power   (out_bus.power),
  .out_last    (out_bus.last)
);
